>>> rtl/tpm_pkg.sv
`timescale 1ns / 1ps
// tpm_pkg: shared types and constants of the throttle plausibility monitor
// no dependencies

package tpm_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int NOW_W         = 32;
    localparam int VAL_W         = 16;
    localparam int SUM_W         = VAL_W + 1;
    localparam int NUM_CHECKS    = 7;

    // stream widths, padded to whole bytes
    localparam int S_DATA_W = 168;
    localparam int M_DATA_W = 16;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMEOUT    = 2'd0,
        CFG_PAIR_TOL   = 2'd1,
        CFG_TARGET_TOL = 2'd2
    } t_cfg_idx;

    localparam logic [VAL_W-1:0] TIMEOUT_RST    = 16'd100;
    localparam logic [VAL_W-1:0] PAIR_TOL_RST   = 16'd160;  // 10.0 in Q12.4
    localparam logic [SUM_W-1:0] TARGET_TOL_RST = 17'd160;

    // check numbering, same as the fault bit positions
    localparam int CHK_PEDAL_PAIR = 0;
    localparam int CHK_THR_PAIR   = 1;
    localparam int CHK_RANGE0     = 2;
    localparam int CHK_TARGET     = 6;

    // input item as carried on the slave tdata, last member in the low bits
    typedef struct packed {
        logic [3:0]       pad;
        logic [VAL_W-1:0] checked_throttle_b;
        logic [VAL_W-1:0] checked_throttle_a;
        logic [VAL_W-1:0] target_b;
        logic [VAL_W-1:0] target_a;
        logic [3:0]       range_ok;
        logic [VAL_W-1:0] throttle_b;
        logic [VAL_W-1:0] throttle_a;
        logic [VAL_W-1:0] pedal_b;
        logic [VAL_W-1:0] pedal_a;
        logic [NOW_W-1:0] now_ms;
    } t_sample;

    // result item as carried on the master tdata
    typedef struct packed {
        logic [6:0]            pad;
        logic [NUM_CHECKS-1:0] fault_bits;
        logic                  valid_ever;
        logic                  valid_now;
    } t_result;

    function automatic logic [VAL_W-1:0] abs_diff16(input logic [VAL_W-1:0] a,
                                                    input logic [VAL_W-1:0] b);
        logic [VAL_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d;
    endfunction

    function automatic logic [SUM_W-1:0] abs_diff17(input logic [SUM_W-1:0] a,
                                                    input logic [SUM_W-1:0] b);
        logic [SUM_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d;
    endfunction

endpackage

>>> rtl/throttle_plausibility_monitor.sv
`timescale 1ns / 1ps
// throttle_plausibility_monitor: pedal and throttle sensor plausibility checks
// depends on tpm_pkg
//
// usage:
//   slave stream takes one sensor sample per item, master stream returns one
//   result item (valid_now, valid_ever, fault_bits) for every sample.
//   the config port writes timeout_ms, pair_tolerance and target_tolerance;
//   write it only while no item is in flight.
// timing:
//   a sample lands in an input register, the seven compare-and-timestamp checks
//   run between that register and the result register. result shows on the
//   master side once the item moves into the result register. one item per
//   cycle is sustained while the master side holds tready high; the per-check
//   last-good-time registers are updated as the item moves into the result
//   register, so the next item sees them.
// reset:
//   last good times clear to zero, the sticky valid latch sets, registers take
//   their defaults (100 ms, 10.0, 10.0), both stages empty.
// stall:
//   when the master side holds tready low the result register keeps its item,
//   the input register still takes one more sample if it is empty, then tready drops.

module throttle_plausibility_monitor #(
    parameter int TIME_BITS = tpm_pkg::TIME_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // config write port
    input  logic                            i_cfg_we,
    input  logic [tpm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tpm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // sample stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // low to high: now_ms, pedal_a, pedal_b, throttle_a, throttle_b, range_ok,
    // target_a, target_b, checked_throttle_a, checked_throttle_b, zero pad
    input  logic [tpm_pkg::S_DATA_W-1:0]    s_axis_tdata,
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // low to high: valid_now, valid_ever, fault_bits[6:0], zero pad
    output logic [tpm_pkg::M_DATA_W-1:0]    m_axis_tdata
);

    import tpm_pkg::*;

    // configuration
    logic [VAL_W-1:0] r_timeout;
    logic [VAL_W-1:0] r_pair_tol;
    logic [SUM_W-1:0] r_target_tol;

    // check state
    logic [TIME_BITS-1:0]  r_last_good [NUM_CHECKS];
    logic [TIME_BITS-1:0]  n_last_good [NUM_CHECKS];
    logic                  r_all_ok;
    logic                  n_all_ok;

    // input stage and result stage
    logic     r_s1_valid;
    t_sample  r_s1;
    logic     r_out_valid;
    t_result  r_out;
    t_result  n_out;

    logic                  w_s1_adv;
    logic [TIME_BITS-1:0]  w_now;
    logic [NUM_CHECKS-1:0] w_pass;
    logic [NUM_CHECKS-1:0] w_fault;
    logic [SUM_W-1:0]      w_tgt_sum;
    logic [SUM_W-1:0]      w_thr_sum;

    assign w_s1_adv      = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || w_s1_adv;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    // sample time reduced or widened to the time width
    generate
        if (TIME_BITS > NOW_W) begin : g_now_wide
            assign w_now = {{(TIME_BITS-NOW_W){1'b0}}, r_s1.now_ms};
        end else if (TIME_BITS == NOW_W) begin : g_now_same
            assign w_now = r_s1.now_ms;
        end else begin : g_now_narrow
            assign w_now = r_s1.now_ms[TIME_BITS-1:0];
        end
    endgenerate

    assign w_tgt_sum = {1'b0, r_s1.target_a} + {1'b0, r_s1.target_b};
    assign w_thr_sum = {1'b0, r_s1.checked_throttle_a} + {1'b0, r_s1.checked_throttle_b};

    always_comb begin
        w_pass[CHK_PEDAL_PAIR] = abs_diff16(r_s1.pedal_a, r_s1.pedal_b) < r_pair_tol;
        w_pass[CHK_THR_PAIR]   = abs_diff16(r_s1.throttle_a, r_s1.throttle_b) < r_pair_tol;
        w_pass[CHK_RANGE0 +: 4] = r_s1.range_ok;
        w_pass[CHK_TARGET]     = abs_diff17(w_tgt_sum, w_thr_sum) < r_target_tol;
    end

    // a failing check faults only after the timeout, wrapping difference
    always_comb begin
        for (int i = 0; i < NUM_CHECKS; i++) begin
            w_fault[i]     = !w_pass[i] &&
                             ((w_now - r_last_good[i]) >
                              {{(TIME_BITS-VAL_W){1'b0}}, r_timeout});
            n_last_good[i] = w_pass[i] ? w_now : r_last_good[i];
        end
        n_all_ok         = r_all_ok && (w_fault == '0);
        n_out            = '0;
        n_out.valid_now  = (w_fault == '0);
        n_out.valid_ever = n_all_ok;
        n_out.fault_bits = w_fault;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout    <= TIMEOUT_RST;
            r_pair_tol   <= PAIR_TOL_RST;
            r_target_tol <= TARGET_TOL_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TIMEOUT:    r_timeout    <= i_cfg_data[VAL_W-1:0];
                CFG_PAIR_TOL:   r_pair_tol   <= i_cfg_data[VAL_W-1:0];
                CFG_TARGET_TOL: r_target_tol <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_all_ok    <= 1'b1;
            for (int i = 0; i < NUM_CHECKS; i++) begin
                r_last_good[i] <= '0;
            end
        end else begin
            if (s_axis_tready) begin
                r_s1_valid <= s_axis_tvalid;
            end
            if (w_s1_adv) begin
                r_out_valid <= 1'b1;
                r_all_ok    <= n_all_ok;
                for (int i = 0; i < NUM_CHECKS; i++) begin
                    r_last_good[i] <= n_last_good[i];
                end
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_s1 <= t_sample'(s_axis_tdata);
        end
        if (w_s1_adv) begin
            r_out <= n_out;
        end
    end

    a_valid_matches_faults: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.valid_now == (r_out.fault_bits == '0)))
        else $error("valid_now disagrees with fault bits");

    a_ever_implies_now: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.valid_ever) |-> r_out.valid_now)
        else $error("valid_ever set on a faulted item");

    a_latch_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_all_ok |=> !r_all_ok)
        else $error("all-time latch set again without reset");

    a_pass_records_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_adv && w_pass[CHK_TARGET]) |=> (r_last_good[CHK_TARGET] == $past(w_now)))
        else $error("target check pass did not record its time");

    a_fault_needs_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_adv |=> ((r_out.fault_bits & $past(w_pass)) == '0))
        else $error("fault reported on a passing check");

endmodule
